// ===== hw/rtl/telemetry_packet_framer_crc16_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef TELEMETRY_PACKET_FRAMER_CRC16_MACROS_SVH
`define TELEMETRY_PACKET_FRAMER_CRC16_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define TPF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define TPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/tpf_pkg.sv =====
package tpf_pkg;

    localparam int HDR_LEN        = 23;
    localparam int POS_W          = $clog2(HDR_LEN + 2);
    localparam int MAX_NAV_DEF    = 255;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int APB_AW         = 3;

    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [15:0] CRC_SEED     = 16'hFFFF;
    localparam logic [7:0]  FRAME_START  = 8'h23;
    localparam logic [7:0]  EXT_LEN_MARK = 8'hFF;
    localparam logic [7:0]  PKT_TYPE     = 8'd37;

    typedef enum logic {
        OP_START = 1'b0,
        OP_NAV   = 1'b1
    } op_t;

    typedef enum logic {
        REG_PREFIX = 1'b0,
        REG_SERIAL = 1'b1
    } reg_idx_t;

    // One unit of work handed from the front to the back.
    typedef struct packed {
        op_t              kind;
        logic [5:0][15:0] readings;
        logic [7:0]       nav_age;
        logic [7:0]       count;
        logic [15:0]      seq;
        logic [7:0]       data;
        logic             last;
    } cmd_t;

endpackage

// ===== hw/rtl/tpf_feed_if.sv =====
interface tpf_feed_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] pulse_period;
    logic [15:0] pulse_min_period;
    logic [15:0] pulse_count;
    logic [15:0] supply_adc;
    logic [15:0] vertical_adc;
    logic [15:0] vane_adc;
    logic [7:0]  nav_age;
    logic [7:0]  nav_count;
    logic [7:0]  nav_byte;

    modport source (
        output valid, operation, pulse_period, pulse_min_period, pulse_count,
               supply_adc, vertical_adc, vane_adc, nav_age, nav_count, nav_byte,
        input  ready
    );
    modport sink (
        input  valid, operation, pulse_period, pulse_min_period, pulse_count,
               supply_adc, vertical_adc, vane_adc, nav_age, nav_count, nav_byte,
        output ready
    );
endinterface

// ===== hw/rtl/tpf_frame_if.sv =====
interface tpf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       packet_end;

    modport source (output valid, out_byte, run_last, packet_end, input ready);
    modport sink   (input valid, out_byte, run_last, packet_end, output ready);
endinterface

// ===== hw/rtl/telemetry_packet_framer_crc16.sv =====
// Accepted items go into the command queue; the back end registers their bytes for output.
// It sends one byte a cycle while the output is not stalled: a navigation item's byte, with
// the CRC after a packet's last one; a start item's header, with the CRC if no navigation data.
// A two-entry command queue lets the front keep taking items while the back end is busy.
// Reset (asynchronous, active low) clears the sequence counter, packet state, queue,
// output valid flag and both configuration registers; the CRC is seeded at each packet.
module telemetry_packet_framer_crc16 #(
    parameter int MAX_NAV_BYTES = tpf_pkg::MAX_NAV_DEF,
    parameter int QUEUE_DEPTH   = tpf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    tpf_feed_if.sink                   feed,
    tpf_frame_if.source                frame,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tpf_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import tpf_pkg::*;

    logic [7:0]  prefix_reg;
    logic [15:0] serial_reg;
    logic        wr_en;
    reg_idx_t    reg_sel;

    cmd_t        q_entry, q_head;
    logic        q_push, q_pop, q_full, q_empty;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_comb
    begin
        case (reg_sel)
            REG_PREFIX: prdata = {24'h000000, prefix_reg};
            REG_SERIAL: prdata = {16'h0000, serial_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            serial_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_PREFIX: prefix_reg <= pwdata[7:0];
                REG_SERIAL: serial_reg <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    tpf_front #(
        .MAX_NAV_BYTES(MAX_NAV_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .feed    (feed),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    tpf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .entry_in (q_entry),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    tpf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .prefix  (prefix_reg),
        .serial  (serial_reg),
        .frame   (frame)
    );

endmodule

// ===== hw/rtl/tpf_front.sv =====
module tpf_front #(
    parameter int MAX_NAV_BYTES = tpf_pkg::MAX_NAV_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tpf_feed_if.sink      feed,
    input  logic          q_full,
    output logic          q_push,
    output tpf_pkg::cmd_t q_entry
);
    import tpf_pkg::*;

    localparam logic [7:0] MaxCnt = 8'(MAX_NAV_BYTES);

    logic [15:0] seq_reg, seq_next;
    logic        in_packet_reg, in_packet_next;
    logic [7:0]  left_reg, left_next;
    logic        accept;
    logic [7:0]  cnt_sat;

    assign feed.ready = !q_full;
    assign accept     = feed.valid && feed.ready;
    assign cnt_sat    = (feed.nav_count > MaxCnt) ? MaxCnt : feed.nav_count;

    always_comb
    begin
        q_entry.kind     = op_t'(feed.operation);
        q_entry.readings = {feed.vane_adc, feed.vertical_adc, feed.supply_adc,
                            feed.pulse_count, feed.pulse_min_period, feed.pulse_period};
        q_entry.nav_age  = feed.nav_age;
        q_entry.count    = cnt_sat;
        q_entry.seq      = seq_reg;
        q_entry.data     = feed.nav_byte;
        q_entry.last     = (left_reg == 8'd1);

        q_push         = 1'b0;
        seq_next       = seq_reg;
        in_packet_next = in_packet_reg;
        left_next      = left_reg;

        if (accept)
        begin
            if (feed.operation == OP_START)
            begin
                // A start abandons any open packet.
                q_push         = 1'b1;
                seq_next       = seq_reg + 16'd1;
                in_packet_next = (cnt_sat != 8'd0);
                left_next      = cnt_sat;
            end
            else if (in_packet_reg && left_reg != 8'd0)
            begin
                q_push    = 1'b1;
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1)
                begin
                    in_packet_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= '0;
            in_packet_reg <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            seq_reg       <= seq_next;
            in_packet_reg <= in_packet_next;
            left_reg      <= left_next;
        end
    end

endmodule

// ===== hw/rtl/tpf_queue.sv =====
module tpf_queue #(
    parameter int DEPTH = tpf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tpf_pkg::cmd_t entry_in,
    output logic          full,
    input  logic          pop,
    output tpf_pkg::cmd_t head,
    output logic          empty
);
    import tpf_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    cmd_t            mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full  = (count_reg == CntW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/tpf_back.sv =====
module tpf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  tpf_pkg::cmd_t head,
    input  logic          q_empty,
    output logic          q_pop,
    input  logic [7:0]    prefix,
    input  logic [15:0]   serial,
    tpf_frame_if.source   frame
);
    import tpf_pkg::*;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] hdr_byte(input cmd_t c, input logic [POS_W-1:0] p,
                                            input logic [7:0] pfx, input logic [15:0] sn);
        logic [15:0] len;
        logic [7:0]  r;
        len = 16'(HDR_LEN + 2) + 16'(c.count);
        case (p)
            5'd0:    r = FRAME_START;
            5'd1:    r = pfx;
            5'd2:    r = sn[15:8];
            5'd3:    r = sn[7:0];
            5'd4:    r = EXT_LEN_MARK;
            5'd5:    r = PKT_TYPE;
            5'd6:    r = len[15:8];
            5'd7:    r = len[7:0];
            5'd8:    r = c.seq[15:8];
            5'd9:    r = c.seq[7:0];
            5'd10:   r = c.readings[0][15:8];
            5'd11:   r = c.readings[0][7:0];
            5'd12:   r = c.readings[1][15:8];
            5'd13:   r = c.readings[1][7:0];
            5'd14:   r = c.readings[2][15:8];
            5'd15:   r = c.readings[2][7:0];
            5'd16:   r = c.readings[3][15:8];
            5'd17:   r = c.readings[3][7:0];
            5'd18:   r = c.readings[4][15:8];
            5'd19:   r = c.readings[4][7:0];
            5'd20:   r = c.readings[5][15:8];
            5'd21:   r = c.readings[5][7:0];
            default: r = c.nav_age;
        endcase
        return r;
    endfunction

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             run_last_reg;
    logic             packet_end_reg;

    logic             advance, fire;
    logic [7:0]       byte_v;
    logic             last_v, end_v, done_v, upd_v, seed_v;

    assign advance = !valid_reg || frame.ready;
    assign fire    = advance && !q_empty;
    assign q_pop   = fire && done_v;

    always_comb
    begin
        byte_v = head.data;
        last_v = 1'b0;
        end_v  = 1'b0;
        done_v = 1'b0;
        upd_v  = 1'b0;
        seed_v = 1'b0;
        if (head.kind == OP_START)
        begin
            if (pos_reg < POS_W'(HDR_LEN))
            begin
                byte_v = hdr_byte(head, pos_reg, prefix, serial);
                // The leading frame mark is not covered by the CRC.
                seed_v = (pos_reg == '0);
                upd_v  = (pos_reg != '0);
                if (pos_reg == POS_W'(HDR_LEN - 1) && head.count != 8'd0)
                begin
                    last_v = 1'b1;
                    done_v = 1'b1;
                end
            end
            else if (pos_reg == POS_W'(HDR_LEN))
            begin
                byte_v = crc_reg[15:8];
            end
            else
            begin
                byte_v = crc_reg[7:0];
                last_v = 1'b1;
                end_v  = 1'b1;
                done_v = 1'b1;
            end
        end
        else
        begin
            if (pos_reg == '0)
            begin
                byte_v = head.data;
                upd_v  = 1'b1;
                last_v = !head.last;
                done_v = !head.last;
            end
            else if (pos_reg == POS_W'(1))
            begin
                byte_v = crc_reg[15:8];
            end
            else
            begin
                byte_v = crc_reg[7:0];
                last_v = 1'b1;
                end_v  = 1'b1;
                done_v = 1'b1;
            end
        end

        crc_next = crc_reg;
        pos_next = pos_reg;
        if (fire)
        begin
            if (seed_v)
            begin
                crc_next = CRC_SEED;
            end
            else if (upd_v)
            begin
                crc_next = crc_byte(crc_reg, byte_v);
            end
            pos_next = done_v ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            crc_reg   <= CRC_SEED;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            if (advance)
            begin
                valid_reg <= fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg       <= byte_v;
            run_last_reg   <= last_v;
            packet_end_reg <= end_v;
        end
    end

    assign frame.valid      = valid_reg;
    assign frame.out_byte   = byte_reg;
    assign frame.run_last   = run_last_reg;
    assign frame.packet_end = packet_end_reg;

endmodule

// ===== hw/rtl/tpf_checker.sv =====
`include "telemetry_packet_framer_crc16_macros.svh"

module tpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_packet_end
);
    import tpf_pkg::*;

    logic at_start_reg;
    logic seen_input_reg;
    logic out_acc;

    assign out_acc = out_valid && out_ready;

    // Tracks whether the next byte sent must open a new packet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg   <= 1'b1;
            seen_input_reg <= 1'b0;
        end
        else
        begin
            if (out_acc)
            begin
                at_start_reg <= out_packet_end;
            end
            if (in_valid && in_ready)
            begin
                seen_input_reg <= 1'b1;
            end
        end
    end

    `TPF_ASSERT_SAME(a_opens_with_mark, out_acc && at_start_reg, out_byte == FRAME_START)
    `TPF_ASSERT_SAME(a_no_output_unprompted, out_valid, seen_input_reg)
    `TPF_ASSERT_NEXT(a_valid_held, out_valid && !out_ready, out_valid)
    `TPF_ASSERT_NEXT(a_byte_held, out_valid && !out_ready, $stable(out_byte))

endmodule

bind telemetry_packet_framer_crc16 tpf_checker u_tpf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (feed.valid),
    .in_ready       (feed.ready),
    .out_valid      (frame.valid),
    .out_ready      (frame.ready),
    .out_byte       (frame.out_byte),
    .out_packet_end (frame.packet_end)
);

// ===== tb/tb_telemetry_packet_framer_crc16.sv =====
module tb_telemetry_packet_framer_crc16;

    import tpf_pkg::*;

    localparam int MAX_NAV = MAX_NAV_DEF;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    typedef struct packed {
        op_t              op;
        logic [5:0][15:0] rd;
        logic [7:0]       age;
        logic [7:0]       cnt;
        logic [7:0]       nb;
    } feed_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pend;
    } frame_beat_t;

    // nres and plen are typed-in expectations, -1 where the predictor alone decides.
    typedef struct {
        row_kind_t        kind;
        op_t              op;
        logic [5:0][15:0] rd;
        logic [7:0]       age;
        logic [7:0]       cnt;
        logic [7:0]       nb;
        int               nres;
        int               plen;
        logic [7:0]       pre;
        logic [15:0]      ser;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    tpf_feed_if  feed_bus ();
    tpf_frame_if frame_bus ();

    telemetry_packet_framer_crc16 dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .feed    (feed_bus),
        .frame   (frame_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Framing state as the block should hold it.
    logic [7:0]  cur_prefix;
    logic [15:0] cur_serial;
    logic [15:0] pkt_seq;
    logic [15:0] run_crc;
    logic [7:0]  nav_left;
    logic        pkt_open;

    frame_beat_t bytes_due [$];
    int          fault_cnt;
    bit          idle_en;

    dir_row_t dir_tab [18];

    task automatic flag(input string msg);
        fault_cnt++;
        if (fault_cnt <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // Works out the bytes one accepted item puts on the frame stream.
    task automatic frame_item(input feed_item_t it, output int nres);
        logic [7:0]  hdr [HDR_LEN];
        logic [15:0] plen;
        int          cnt;
        nres = 0;
        if (it.op == OP_START)
        begin
            cnt = it.cnt;
            if (cnt > MAX_NAV)
            begin
                cnt = MAX_NAV;
            end
            plen = 16'(HDR_LEN + 2 + cnt);
            hdr[0] = FRAME_START;
            hdr[1] = cur_prefix;
            hdr[2] = cur_serial[15:8];
            hdr[3] = cur_serial[7:0];
            hdr[4] = EXT_LEN_MARK;
            hdr[5] = PKT_TYPE;
            hdr[6] = plen[15:8];
            hdr[7] = plen[7:0];
            hdr[8] = pkt_seq[15:8];
            hdr[9] = pkt_seq[7:0];
            for (int i = 0; i < 6; i++)
            begin
                hdr[10 + 2 * i] = it.rd[i][15:8];
                hdr[11 + 2 * i] = it.rd[i][7:0];
            end
            hdr[22] = it.age;
            // The leading frame marker is left out of the checksum.
            run_crc = CRC_SEED;
            for (int i = 1; i < HDR_LEN; i++)
            begin
                run_crc = crc16_byte(run_crc, hdr[i]);
            end
            pkt_seq++;
            for (int i = 0; i < HDR_LEN; i++)
            begin
                bytes_due.push_back(frame_beat_t'{hdr[i], (cnt != 0 && i == HDR_LEN - 1), 1'b0});
            end
            nres = HDR_LEN;
            if (cnt == 0)
            begin
                bytes_due.push_back(frame_beat_t'{run_crc[15:8], 1'b0, 1'b0});
                bytes_due.push_back(frame_beat_t'{run_crc[7:0], 1'b1, 1'b1});
                nres += 2;
                pkt_open = 1'b0;
                nav_left = 8'd0;
            end
            else
            begin
                pkt_open = 1'b1;
                nav_left = 8'(cnt);
            end
        end
        else if (pkt_open && nav_left != 8'd0)
        begin
            run_crc = crc16_byte(run_crc, it.nb);
            nav_left--;
            if (nav_left != 8'd0)
            begin
                bytes_due.push_back(frame_beat_t'{it.nb, 1'b1, 1'b0});
                nres = 1;
            end
            else
            begin
                bytes_due.push_back(frame_beat_t'{it.nb, 1'b0, 1'b0});
                bytes_due.push_back(frame_beat_t'{run_crc[15:8], 1'b0, 1'b0});
                bytes_due.push_back(frame_beat_t'{run_crc[7:0], 1'b1, 1'b1});
                nres = 3;
                pkt_open = 1'b0;
            end
        end
    endtask

    task automatic send_item(input feed_item_t it, output int nres);
        int gap;
        gap = idle_en ? $urandom_range(0, 5) : 0;
        if (gap != 0)
        begin
            feed_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        feed_bus.valid            <= 1'b1;
        feed_bus.operation        <= it.op;
        feed_bus.pulse_period     <= it.rd[0];
        feed_bus.pulse_min_period <= it.rd[1];
        feed_bus.pulse_count      <= it.rd[2];
        feed_bus.supply_adc       <= it.rd[3];
        feed_bus.vertical_adc     <= it.rd[4];
        feed_bus.vane_adc         <= it.rd[5];
        feed_bus.nav_age          <= it.age;
        feed_bus.nav_count        <= it.cnt;
        feed_bus.nav_byte         <= it.nb;
        @(posedge clk);
        while (!feed_bus.ready) @(posedge clk);
        frame_item(it, nres);
    endtask

    // Writes a register, then reads it back in a second transfer.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        logic [31:0] keep;
        keep = (idx == REG_PREFIX) ? {24'd0, val[7:0]} : {16'd0, val[15:0]};
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (idx == REG_PREFIX)
        begin
            cur_prefix = val[7:0];
        end
        else
        begin
            cur_serial = val[15:0];
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== keep)
        begin
            flag($sformatf("register %s read: expected %08h, got %08h",
                           idx.name(), keep, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drain();
        int waited;
        waited = 0;
        feed_bus.valid <= 1'b0;
        while (bytes_due.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (bytes_due.size() != 0)
        begin
            flag($sformatf("%0d frame bytes never arrived", bytes_due.size()));
            bytes_due.delete();
        end
        // A stray navigation byte leaves nothing to wait for, so give the block time.
        repeat (30) @(posedge clk);
    endtask

    function automatic feed_item_t rand_item(input op_t op);
        feed_item_t it;
        it.op = op;
        for (int i = 0; i < 6; i++)
        begin
            it.rd[i] = 16'($urandom);
        end
        it.age = 8'($urandom);
        it.cnt = 8'($urandom);
        it.nb  = 8'($urandom);
        return it;
    endfunction

    task automatic random_phase(input int target, input bit with_big);
        feed_item_t it;
        int sent;
        int nres;
        int cnt;
        int r;
        int stop;
        sent = 0;
        if (with_big)
        begin
            it = rand_item(OP_START);
            it.cnt = 8'd255;
            send_item(it, nres);
            for (int j = 0; j < 255; j++)
            begin
                send_item(rand_item(OP_NAV), nres);
            end
        end
        while (sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                // Stray navigation byte, ignored unless a packet is still open.
                send_item(rand_item(OP_NAV), nres);
                if (nres != 0)
                begin
                    sent++;
                end
            end
            else if (r < 16)
            begin
                // Packet with any count, often left open for the next start to abandon.
                it = rand_item(OP_START);
                send_item(it, nres);
                sent++;
                stop = $urandom_range(0, 3);
                for (int j = 0; j < stop; j++)
                begin
                    send_item(rand_item(OP_NAV), nres);
                    sent++;
                end
            end
            else
            begin
                cnt = (r < 26) ? $urandom_range(9, 40) : $urandom_range(0, 8);
                it = rand_item(OP_START);
                it.cnt = 8'(cnt);
                send_item(it, nres);
                sent++;
                for (int j = 0; j < cnt; j++)
                begin
                    if ($urandom_range(0, 99) < 3)
                    begin
                        break;
                    end
                    send_item(rand_item(OP_NAV), nres);
                    sent++;
                end
            end
        end
        if (pkt_open)
        begin
            it = rand_item(OP_START);
            it.cnt = 8'd0;
            send_item(it, nres);
        end
    endtask

    always @(posedge clk)
    begin
        frame_beat_t got;
        frame_beat_t want;
        if (rst_n && frame_bus.valid && frame_bus.ready)
        begin
            got = frame_beat_t'{frame_bus.out_byte, frame_bus.run_last, frame_bus.packet_end};
            if (bytes_due.size() == 0)
            begin
                flag($sformatf("unexpected frame byte %02h last %0b end %0b",
                               got.data, got.last, got.pend));
            end
            else
            begin
                want = bytes_due.pop_front();
                if (got !== want)
                begin
                    flag($sformatf("frame byte: expected %02h last %0b end %0b, got %02h last %0b end %0b",
                                   want.data, want.last, want.pend,
                                   got.data, got.last, got.pend));
                end
            end
        end
    end

    // Receiving side: when idle_en is set, a random stall before each byte it takes.
    initial
    begin
        int stall;
        frame_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = idle_en ? $urandom_range(0, 5) : 0;
            if (stall != 0)
            begin
                frame_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            frame_bus.ready <= 1'b1;
            @(posedge clk);
            while (!frame_bus.valid) @(posedge clk);
        end
    end

    initial
    begin
        #4000000;
        $display("tb_telemetry_packet_framer_crc16: FAIL");
        $finish;
    end

    initial
    begin
        feed_item_t  it;
        frame_beat_t beat;
        int          nres;
        int          base;

        dir_tab = '{
            '{ROW_ITEM, OP_NAV,   {6{16'hFFFF}},                  8'hFF, 8'hFF, 8'hFF,  0,  -1,
              8'h00, 16'h0000},
            '{ROW_ITEM, OP_START, 96'h0,                          8'h00, 8'h00, 8'h00, 25,  25,
              8'h00, 16'h0000},
            '{ROW_ITEM, OP_START, {6{16'hFFFF}},                  8'hFF, 8'h00, 8'hFF, 25,  25,
              8'h00, 16'h0000},
            '{ROW_ITEM, OP_START, 96'h0123_4567_89AB_CDEF_FEDC_BA98, 8'h3C, 8'h01, 8'hC3, 23, 26,
              8'h00, 16'h0000},
            '{ROW_ITEM, OP_NAV,   {6{16'hFFFF}},                  8'hFF, 8'hFF, 8'h00,  3,  -1,
              8'h00, 16'h0000},
            '{ROW_ITEM, OP_NAV,   96'h0,                          8'h00, 8'h00, 8'h5A,  0,  -1,
              8'h00, 16'h0000},
            '{ROW_CFG,  OP_START, 96'h0,                          8'h00, 8'h00, 8'h00, -1,  -1,
              8'hFF, 16'hFFFF},
            '{ROW_ITEM, OP_START, 96'h8000_0001_7FFF_FFFE_00FF_FF00, 8'h80, 8'h02, 8'h01, 23, 27,
              8'h00, 16'h0000},
            '{ROW_ITEM, OP_NAV,   96'h0,                          8'h00, 8'h00, 8'hFF,  1,  -1,
              8'h00, 16'h0000},
            '{ROW_ITEM, OP_NAV,   {6{16'hFFFF}},                  8'hFF, 8'hFF, 8'hA5,  3,  -1,
              8'h00, 16'h0000},
            '{ROW_ITEM, OP_START, 96'h5555_AAAA_3333_CCCC_0F0F_F0F0, 8'h01, 8'h03, 8'hFF, 23, 28,
              8'h00, 16'h0000},
            '{ROW_ITEM, OP_NAV,   96'h0,                          8'h00, 8'h00, 8'h3C,  1,  -1,
              8'h00, 16'h0000},
            // Start while a packet is open: the open one is dropped without a checksum.
            '{ROW_ITEM, OP_START, 96'h0,                          8'h00, 8'h00, 8'h00, 25,  25,
              8'h00, 16'h0000},
            '{ROW_ITEM, OP_START, {6{16'hFFFF}},                  8'hFF, 8'hFF, 8'h00, 23, 280,
              8'h00, 16'h0000},
            '{ROW_ITEM, OP_NAV,   96'h0,                          8'h00, 8'h00, 8'h01,  1,  -1,
              8'h00, 16'h0000},
            '{ROW_ITEM, OP_NAV,   96'h0,                          8'h00, 8'h00, 8'h80,  1,  -1,
              8'h00, 16'h0000},
            '{ROW_ITEM, OP_START, 96'h1234_5678_9ABC_DEF0_0000_FFFF, 8'h7F, 8'h01, 8'h00, 23, 26,
              8'h00, 16'h0000},
            '{ROW_ITEM, OP_NAV,   {6{16'hFFFF}},                  8'hFF, 8'hFF, 8'h7E,  3,  -1,
              8'h00, 16'h0000}
        };

        rst_n                     <= 1'b0;
        psel                      <= 1'b0;
        penable                   <= 1'b0;
        pwrite                    <= 1'b0;
        paddr                     <= '0;
        pwdata                    <= '0;
        feed_bus.valid            <= 1'b0;
        feed_bus.operation        <= OP_START;
        feed_bus.pulse_period     <= '0;
        feed_bus.pulse_min_period <= '0;
        feed_bus.pulse_count      <= '0;
        feed_bus.supply_adc       <= '0;
        feed_bus.vertical_adc     <= '0;
        feed_bus.vane_adc         <= '0;
        feed_bus.nav_age          <= '0;
        feed_bus.nav_count        <= '0;
        feed_bus.nav_byte         <= '0;

        cur_prefix = 8'h00;
        cur_serial = 16'h0000;
        pkt_seq    = 16'h0000;
        run_crc    = CRC_SEED;
        nav_left   = 8'd0;
        pkt_open   = 1'b0;
        fault_cnt  = 0;
        idle_en    = 1'b1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[n])
        begin
            if (dir_tab[n].kind == ROW_CFG)
            begin
                wait_drain();
                write_reg(REG_PREFIX, {24'd0, dir_tab[n].pre});
                write_reg(REG_SERIAL, {16'd0, dir_tab[n].ser});
            end
            else
            begin
                it = feed_item_t'{dir_tab[n].op, dir_tab[n].rd, dir_tab[n].age,
                                  dir_tab[n].cnt, dir_tab[n].nb};
                send_item(it, nres);
                if (dir_tab[n].nres >= 0 && nres != dir_tab[n].nres)
                begin
                    flag($sformatf("row %0d: expected %0d frame bytes, predicted %0d",
                                   n, dir_tab[n].nres, nres));
                end
                else if (dir_tab[n].plen >= 0)
                begin
                    // The length field is typed in, so check the block against it directly.
                    base = bytes_due.size() - nres;
                    beat = bytes_due[base + 6];
                    beat.data = 8'(dir_tab[n].plen >> 8);
                    bytes_due[base + 6] = beat;
                    beat = bytes_due[base + 7];
                    beat.data = 8'(dir_tab[n].plen);
                    bytes_due[base + 7] = beat;
                end
            end
        end
        wait_drain();

        write_reg(REG_PREFIX, $urandom);
        write_reg(REG_SERIAL, $urandom);
        random_phase(80, 1'b0);
        wait_drain();

        idle_en = 1'b0;
        write_reg(REG_PREFIX, 32'd0);
        write_reg(REG_SERIAL, 32'd0);
        random_phase(50, 1'b0);
        wait_drain();

        idle_en = 1'b1;
        write_reg(REG_PREFIX, $urandom);
        write_reg(REG_SERIAL, $urandom);
        random_phase(70, 1'b0);
        wait_drain();

        write_reg(REG_PREFIX, $urandom);
        write_reg(REG_SERIAL, $urandom);
        random_phase(60, 1'b0);
        wait_drain();

        if (fault_cnt == 0)
        begin
            $display("tb_telemetry_packet_framer_crc16: PASS");
        end
        else
        begin
            $display("tb_telemetry_packet_framer_crc16: FAIL");
        end
        $finish;
    end

endmodule
